@@ sv/slnv_pkg.sv @@
// Shared constants, types and codes for the sorted-list nearest value search.
`timescale 1ns / 1ps

package slnv_pkg;

    localparam int LANDMARK_COUNT = 16;
    localparam int MAX_OBJECTS    = 256;
    localparam int TABLE_DEPTH    = LANDMARK_COUNT * MAX_OBJECTS;

    localparam int POS_W  = $clog2(TABLE_DEPTH);
    localparam int ID_W   = 16;
    localparam int DIST_W = 31;
    localparam int LM_W   = 4;
    localparam int CFG_W  = 9;
    localparam int REQ_W  = 2;

    localparam logic [CFG_W-1:0] SEG_RESET = CFG_W'(MAX_OBJECTS);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_FIND = 2'd1,
        REQ_NEXT = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_SEARCH,
        ST_SEARCH_WAIT,
        ST_PAIR_A,
        ST_PAIR_B,
        ST_PAIR_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        logic [ID_W-1:0]   object;
        logic [DIST_W-1:0] distance;
    } tbl_wr_t;

endpackage

@@ sv/sorted_list_nearest_value_search.sv @@
// Top level: request sequencer for nearest-distance lookup over a segmented sorted table.
//
//  channel | ports                      | direction | beat
//  --------+----------------------------+-----------+-------------------------------
//  s_      | s_valid / s_ready          | in        | load, find or next request
//  m_      | m_valid / m_ready          | out       | one result per find or next
//  cfg_    | cfg_valid / cfg_ready      | in        | objects_per_landmark write
//
// A load is written to the table on its accept beat. A find runs a binary search with one
// table read per halving step (SEARCH then SEARCH_WAIT, 7 or 8 steps for a 256-entry
// segment), then reads the final pair (PAIR_A, PAIR_B, PAIR_CMP) unless the segment has one
// entry, and the pick in DONE. A next reads one candidate when one side is used up, both when
// neither is, none when both are. The single table read port serializes these reads; DONE also
// holds while the previous result waits on m_ready. Reset is synchronous; the table holds no
// reset value. The output register lets a new request start while a result waits on m_ready.
`timescale 1ns / 1ps

module sorted_list_nearest_value_search (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [slnv_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [slnv_pkg::REQ_W-1:0]     s_req_type,
    input  logic [slnv_pkg::LM_W-1:0]      s_landmark,
    input  logic [slnv_pkg::DIST_W-1:0]    s_query_distance,
    input  logic [slnv_pkg::POS_W-1:0]     s_entry_position,
    input  logic [slnv_pkg::ID_W-1:0]      s_entry_object,
    input  logic [slnv_pkg::DIST_W-1:0]    s_entry_distance,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic [slnv_pkg::ID_W-1:0]      m_object_id,
    output logic [slnv_pkg::DIST_W-1:0]    m_object_distance,
    output logic [slnv_pkg::POS_W-1:0]     m_position
);

    localparam int POS_W  = slnv_pkg::POS_W;
    localparam int DIST_W = slnv_pkg::DIST_W;
    localparam int ID_W   = slnv_pkg::ID_W;
    localparam int CFG_W  = slnv_pkg::CFG_W;

    function automatic logic [DIST_W-1:0] absdiff(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    slnv_pkg::state_t   state_reg, state_next;
    logic [CFG_W-1:0]   seg_cfg_reg;
    logic               next_mode_reg, next_mode_next;
    logic               found_reg, found_next;
    logic [DIST_W-1:0]  q_reg, q_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   end_reg, end_next;
    logic [POS_W-1:0]   s_reg, s_next;
    logic [POS_W-1:0]   e_reg, e_next;
    logic [POS_W-1:0]   a_reg, a_next;
    logic [POS_W-1:0]   b_reg, b_next;
    logic [DIST_W-1:0]  da_reg, da_next;
    logic [POS_W-1:0]   pick_reg, pick_next;
    logic [POS_W-1:0]   left_reg, left_next;
    logic [POS_W-1:0]   right_reg, right_next;

    logic               m_valid_reg;
    logic               m_found_reg;
    logic [ID_W-1:0]    m_object_reg;
    logic [DIST_W-1:0]  m_distance_reg;
    logic [POS_W-1:0]   m_position_reg;

    logic               s_beat;
    logic               out_free;
    logic [CFG_W-1:0]   seg_n;
    logic [POS_W:0]     seg_start;
    logic [POS_W:0]     seg_end;
    logic [POS_W:0]     mid_sum;
    logic [POS_W-1:0]   mid;
    logic               span_wide;
    logic               lx, rx;
    logic               a_wins;

    logic [POS_W-1:0]   rd_addr;
    logic [ID_W-1:0]    rd_object;
    logic [DIST_W-1:0]  rd_distance;
    slnv_pkg::tbl_wr_t  tbl_wr;

    // address seen by the table last cycle, so DONE knows the read data is current
    logic [POS_W-1:0]   rd_addr_q_reg;
    logic               done_load;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == slnv_pkg::ST_IDLE);
    assign s_beat    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // segment size clamped to 1..MAX_OBJECTS
    always_comb begin
        if (seg_cfg_reg == '0) begin
            seg_n = CFG_W'(1);
        end else if (seg_cfg_reg > slnv_pkg::SEG_RESET) begin
            seg_n = slnv_pkg::SEG_RESET;
        end else begin
            seg_n = seg_cfg_reg;
        end
    end

    assign seg_start = (POS_W+1)'(s_landmark) * (POS_W+1)'(seg_n);
    assign seg_end   = seg_start + (POS_W+1)'(seg_n) - (POS_W+1)'(1);

    assign mid_sum   = {1'b0, s_reg} + {1'b0, e_reg};
    assign mid       = mid_sum[POS_W:1];
    assign span_wide = (e_reg - s_reg) > POS_W'(1);

    assign lx     = (left_reg <= start_reg);
    assign rx     = (right_reg >= end_reg);
    assign a_wins = absdiff(da_reg, q_reg) < absdiff(rd_distance, q_reg);

    assign done_load = (state_reg == slnv_pkg::ST_DONE) && out_free &&
                       (rd_addr_q_reg == pick_reg);

    assign tbl_wr.en       = s_beat && (s_req_type == slnv_pkg::REQ_LOAD);
    assign tbl_wr.addr     = s_entry_position;
    assign tbl_wr.object   = s_entry_object;
    assign tbl_wr.distance = s_entry_distance;

    slnv_table u_table (
        .aclk        (aclk),
        .wr          (tbl_wr),
        .rd_addr     (rd_addr),
        .rd_object   (rd_object),
        .rd_distance (rd_distance)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            slnv_pkg::ST_IDLE: begin
                if (s_beat) begin
                    case (s_req_type)
                        slnv_pkg::REQ_FIND: state_next = slnv_pkg::ST_SEARCH;
                        slnv_pkg::REQ_NEXT: state_next = slnv_pkg::ST_NEXT;
                        default:            state_next = slnv_pkg::ST_IDLE;
                    endcase
                end
            end
            slnv_pkg::ST_NEXT: begin
                if (lx || rx) begin
                    state_next = slnv_pkg::ST_DONE;
                end else begin
                    state_next = slnv_pkg::ST_PAIR_A;
                end
            end
            slnv_pkg::ST_SEARCH: begin
                if (span_wide) begin
                    state_next = slnv_pkg::ST_SEARCH_WAIT;
                end else if (s_reg == e_reg) begin
                    state_next = slnv_pkg::ST_DONE;
                end else begin
                    state_next = slnv_pkg::ST_PAIR_A;
                end
            end
            slnv_pkg::ST_SEARCH_WAIT: state_next = slnv_pkg::ST_SEARCH;
            slnv_pkg::ST_PAIR_A:      state_next = slnv_pkg::ST_PAIR_B;
            slnv_pkg::ST_PAIR_B:      state_next = slnv_pkg::ST_PAIR_CMP;
            slnv_pkg::ST_PAIR_CMP:    state_next = slnv_pkg::ST_DONE;
            slnv_pkg::ST_DONE: begin
                // DONE waits until the pick read has landed and the output is free
                if (done_load) begin
                    state_next = slnv_pkg::ST_IDLE;
                end
            end
            default: state_next = slnv_pkg::ST_IDLE;
        endcase
    end

    // datapath and table address
    always_comb begin
        next_mode_next = next_mode_reg;
        found_next     = found_reg;
        q_next         = q_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        da_next        = da_reg;
        pick_next      = pick_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        rd_addr        = pick_reg;

        unique case (state_reg)
            slnv_pkg::ST_IDLE: begin
                if (s_beat) begin
                    next_mode_next = (s_req_type == slnv_pkg::REQ_NEXT);
                    found_next     = 1'b1;
                    q_next         = s_query_distance;
                    start_next     = seg_start[POS_W-1:0];
                    end_next       = seg_end[POS_W-1:0];
                    s_next         = seg_start[POS_W-1:0];
                    e_next         = seg_end[POS_W-1:0];
                    // park the read address away from the coming pick
                    pick_next      = ~seg_start[POS_W-1:0];
                end
            end
            slnv_pkg::ST_NEXT: begin
                if (lx && rx) begin
                    found_next = 1'b0;
                end else if (lx) begin
                    pick_next  = right_reg + POS_W'(1);
                    right_next = right_reg + POS_W'(1);
                end else if (rx) begin
                    pick_next = left_reg - POS_W'(1);
                    left_next = left_reg - POS_W'(1);
                end else begin
                    a_next = left_reg - POS_W'(1);
                    b_next = right_reg + POS_W'(1);
                end
            end
            slnv_pkg::ST_SEARCH: begin
                rd_addr = mid;
                if (!span_wide) begin
                    if (s_reg == e_reg) begin
                        pick_next  = s_reg;
                        left_next  = s_reg;
                        right_next = s_reg;
                    end else begin
                        a_next = s_reg;
                        b_next = e_reg;
                    end
                end
            end
            slnv_pkg::ST_SEARCH_WAIT: begin
                rd_addr = mid;
                if (rd_distance < q_reg) begin
                    s_next = mid;
                end else begin
                    e_next = mid;
                end
            end
            slnv_pkg::ST_PAIR_A: begin
                rd_addr = a_reg;
            end
            slnv_pkg::ST_PAIR_B: begin
                rd_addr = b_reg;
                da_next = rd_distance;
            end
            slnv_pkg::ST_PAIR_CMP: begin
                rd_addr   = b_reg;
                pick_next = a_wins ? a_reg : b_reg;
                if (next_mode_reg) begin
                    if (a_wins) begin
                        left_next = a_reg;
                    end else begin
                        right_next = b_reg;
                    end
                end else begin
                    left_next  = a_wins ? a_reg : b_reg;
                    right_next = a_wins ? a_reg : b_reg;
                end
            end
            slnv_pkg::ST_DONE: begin
                rd_addr   = pick_reg;
                pick_next = pick_reg;
            end
            default: begin
                rd_addr = pick_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_addr_q_reg  <= rd_addr;
        q_reg          <= q_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        da_reg         <= da_next;
        pick_reg       <= pick_next;
        next_mode_reg  <= next_mode_next;
        found_reg      <= found_next;
        if (done_load) begin
            m_found_reg    <= found_reg;
            m_object_reg   <= found_reg ? rd_object : '0;
            m_distance_reg <= found_reg ? rd_distance : '0;
            m_position_reg <= found_reg ? pick_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slnv_pkg::ST_IDLE;
            seg_cfg_reg <= slnv_pkg::SEG_RESET;
            left_reg    <= '0;
            right_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                seg_cfg_reg <= cfg_data;
            end
            left_reg  <= left_next;
            right_reg <= right_next;
            if (done_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = m_found_reg;
    assign m_object_id       = m_object_reg;
    assign m_object_distance = m_distance_reg;
    assign m_position        = m_position_reg;

endmodule

@@ sv/slnv_table.sv @@
// Entry table: object id and distance memories, one write port, one registered read port.
`timescale 1ns / 1ps

module slnv_table (
    input  logic                         aclk,
    input  slnv_pkg::tbl_wr_t            wr,
    input  logic [slnv_pkg::POS_W-1:0]   rd_addr,
    output logic [slnv_pkg::ID_W-1:0]    rd_object,
    output logic [slnv_pkg::DIST_W-1:0]  rd_distance
);

    logic [slnv_pkg::ID_W-1:0]   object_mem   [slnv_pkg::TABLE_DEPTH];
    logic [slnv_pkg::DIST_W-1:0] distance_mem [slnv_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            object_mem[wr.addr]   <= wr.object;
            distance_mem[wr.addr] <= wr.distance;
        end
        rd_object   <= object_mem[rd_addr];
        rd_distance <= distance_mem[rd_addr];
    end

endmodule
